FILE: sv/wtcw_pkg.sv
package wtcw_pkg;

  // Fixed-point formats
  localparam int ANGLE_BITS    = 16;
  localparam int ROW_FRAC_BITS = 4;
  localparam int ACC_FRAC_BITS = 16;

  // Field and register widths
  localparam int ROW_W    = 16;                      // Q12.4 rows and wall height
  localparam int ACC_W    = 24;                      // Q8.16 texel row accumulator
  localparam int ACC_INT_W = ACC_W - ACC_FRAC_BITS;  // integer texel row bits
  localparam int SH_W     = 11;                      // screen height register
  localparam int TW_W     = 9;                       // texture width / height registers
  localparam int CFG_W    = SH_W;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W    = 11;                      // signed texel column
  localparam int SCOL_W   = 12;
  localparam int OROW_W   = ROW_W - ROW_FRAC_BITS;
  localparam int ADDR_W   = 16;
  localparam int TEX_W    = 3;
  localparam int STATUS_W = 2;

  // Start row numerator and divider sizing
  localparam int OFFS_W   = SH_W - 1 + ROW_FRAC_BITS + 1;
  localparam int NUM_W    = ROW_W + 3;
  localparam int DVS_W    = ROW_W;
  localparam int DIV_W    = TW_W + ACC_FRAC_BITS + ROW_FRAC_BITS;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam int ADDR_FULL_W = ACC_INT_W + TW_W + 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Stream packing
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;
  localparam int IN_SIDE_LSB  = 0;
  localparam int IN_ANGLE_LSB = 1;
  localparam int IN_DOOR_LSB  = IN_ANGLE_LSB + ANGLE_BITS;
  localparam int IN_OPEN_LSB  = IN_DOOR_LSB + 1;
  localparam int IN_TCOL_LSB  = IN_OPEN_LSB + 1;
  localparam int IN_TOP_LSB   = IN_TCOL_LSB + COL_W;
  localparam int IN_BOT_LSB   = IN_TOP_LSB + ROW_W;
  localparam int IN_WALL_LSB  = IN_BOT_LSB + ROW_W;
  localparam int IN_SCOL_LSB  = IN_WALL_LSB + ROW_W;
  localparam int IN_USED_W    = IN_SCOL_LSB + SCOL_W;
  localparam int OUT_TEX_LSB  = 0;
  localparam int OUT_ADDR_LSB = OUT_TEX_LSB + TEX_W;
  localparam int OUT_COL_LSB  = OUT_ADDR_LSB + ADDR_W;
  localparam int OUT_ROW_LSB  = OUT_COL_LSB + SCOL_W;
  localparam int OUT_USED_W   = OUT_ROW_LSB + OROW_W;

  // Item kinds
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_PIXEL  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_STOP   = 2'd3;

  // Texture codes
  localparam logic [TEX_W-1:0] TEX_NORTH       = 3'd0;
  localparam logic [TEX_W-1:0] TEX_SOUTH       = 3'd1;
  localparam logic [TEX_W-1:0] TEX_WEST        = 3'd2;
  localparam logic [TEX_W-1:0] TEX_EAST        = 3'd3;
  localparam logic [TEX_W-1:0] TEX_DOOR_OPEN   = 3'd4;
  localparam logic [TEX_W-1:0] TEX_DOOR_CLOSED = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

  localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST  = SH_W'(480);
  localparam logic [TW_W-1:0] TEXTURE_WIDTH_RST  = TW_W'(64);
  localparam logic [TW_W-1:0] TEXTURE_HEIGHT_RST = TW_W'(64);

  // Binary angle landmarks
  localparam logic [ANGLE_BITS-1:0] ANG_HALF_PI  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] ANG_PI       = {2'b10, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] ANG_3HALF_PI = {2'b11, {(ANGLE_BITS-2){1'b0}}};

  // Texture choice from hit side, ray angle and door flags
  function automatic logic [TEX_W-1:0] pick_texture(
    input logic                  side,
    input logic [ANGLE_BITS-1:0] angle,
    input logic                  door,
    input logic                  open
  );
    logic [TEX_W-1:0] t;
    if (door) begin
      t = open ? TEX_DOOR_OPEN : TEX_DOOR_CLOSED;
    end else if (side) begin
      t = (angle != '0 && angle < ANG_PI) ? TEX_NORTH : TEX_SOUTH;
    end else begin
      t = (angle > ANG_HALF_PI && angle < ANG_3HALF_PI) ? TEX_WEST : TEX_EAST;
    end
    return t;
  endfunction

endpackage

FILE: sv/wall_texture_column_walker_core.sv
// Wall texture column walker. A begin item (tuser 0) picks the texture and
// sets up one screen column; while it is active, each step item (tuser 1)
// returns one texel address and screen row, or a done/stop status that ends
// the column; a step with no active column is dropped. A begin item with a bad
// wall height or texel column returns a reject status at once. Items are taken
// one at a time; a step or a rejected begin waits in the execute state while
// the output is stalled. An accepted begin makes no result and holds the block
// until its divisions end: the start texel row (not divided when it clamps
// to zero) and the row step are both quotients from one shared restoring
// divider that retires one bit per cycle over a 29-bit dividend. A finished
// result sits in the output register while the next item is accepted.
module wall_texture_column_walker_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [wtcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wtcw_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // wall_side, ray_angle, door_hit, door_open, texel_column, top_row,
  // bottom_row, wall_height, screen_column, zero pad
  input  logic [wtcw_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic                             s_tuser,
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // texture_id, texel_address, out_column, out_row, zero pad
  output logic [wtcw_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [wtcw_pkg::STATUS_W-1:0]    m_tuser
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_MUL      = 3'd2;
  localparam logic [2:0] ST_DIV_ROW  = 3'd3;
  localparam logic [2:0] ST_DIV_STEP = 3'd4;

  logic [2:0] state;

  // configuration
  logic [wtcw_pkg::SH_W-1:0] screen_height;
  logic [wtcw_pkg::TW_W-1:0] texture_width;
  logic [wtcw_pkg::TW_W-1:0] texture_height;

  // latched input item
  logic                               in_func;
  logic                               in_side;
  logic [wtcw_pkg::ANGLE_BITS-1:0]    in_angle;
  logic                               in_door;
  logic                               in_open;
  logic signed [wtcw_pkg::COL_W-1:0]  in_tcol;
  logic signed [wtcw_pkg::ROW_W-1:0]  in_top;
  logic signed [wtcw_pkg::ROW_W-1:0]  in_bot;
  logic signed [wtcw_pkg::ROW_W-1:0]  in_wall;
  logic [wtcw_pkg::SCOL_W-1:0]        in_scol;

  // column state
  logic                               column_active;
  logic signed [wtcw_pkg::ROW_W-1:0]  current_row;
  logic signed [wtcw_pkg::ROW_W-1:0]  end_row;
  logic [wtcw_pkg::ACC_W-1:0]         texel_row_acc;
  logic [wtcw_pkg::ACC_W-1:0]         texel_row_step;
  logic [wtcw_pkg::ACC_INT_W-1:0]     held_texel_column;
  logic [wtcw_pkg::TEX_W-1:0]         held_texture;
  logic [wtcw_pkg::SCOL_W-1:0]        held_column;
  logic signed [wtcw_pkg::NUM_W-1:0]  num;

  // output register fields
  logic [wtcw_pkg::TEX_W-1:0]   out_tex;
  logic [wtcw_pkg::ADDR_W-1:0]  out_addr;
  logic [wtcw_pkg::SCOL_W-1:0]  out_col;
  logic [wtcw_pkg::OROW_W-1:0]  out_row;

  // divider hookup
  logic                         div_start;
  logic [wtcw_pkg::DIV_W-1:0]   div_dividend;
  logic [wtcw_pkg::DVS_W-1:0]   div_divisor;
  logic                         div_done;
  logic [wtcw_pkg::DIV_W-1:0]   div_quotient;

  // combinational helpers
  logic                         out_free;
  logic [wtcw_pkg::TEX_W-1:0]   tex_pick;
  logic                         reject;
  logic signed [wtcw_pkg::NUM_W-1:0] num_calc;
  logic [wtcw_pkg::OFFS_W-1:0]  half_offs;
  logic                         num_pos;
  logic [wtcw_pkg::DIV_W-1:0]   row_dividend;
  logic [wtcw_pkg::DVS_W-1:0]   row_divisor;
  logic [wtcw_pkg::DIV_W-1:0]   step_dividend;
  logic                         at_end;
  logic [wtcw_pkg::ACC_INT_W-1:0] trow;
  logic [wtcw_pkg::ADDR_FULL_W-1:0] addr_full;
  logic                         addr_ovf;
  logic signed [wtcw_pkg::ROW_W:0] row_inc;
  logic signed [wtcw_pkg::ROW_W-1:0] row_next;
  logic [wtcw_pkg::ACC_W:0]     acc_sum;
  logic [wtcw_pkg::ACC_W-1:0]   acc_next;
  logic [wtcw_pkg::ACC_W-1:0]   row_acc_q;
  logic [wtcw_pkg::ACC_W-1:0]   step_q;

  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = (state == ST_IDLE);

  // Begin item: texture, rejection and start row numerator
  always_comb begin
    tex_pick  = wtcw_pkg::pick_texture(in_side, in_angle, in_door, in_open);
    reject    = in_wall[wtcw_pkg::ROW_W-1] || (in_wall == '0) || in_tcol[wtcw_pkg::COL_W-1]
                || ({1'b0, in_tcol[wtcw_pkg::COL_W-2:0]} >= wtcw_pkg::COL_W'(texture_width))
                || (in_tcol[wtcw_pkg::COL_W-2:wtcw_pkg::ACC_INT_W] != '0);
    half_offs = {screen_height[wtcw_pkg::SH_W-1:1], {(wtcw_pkg::ROW_FRAC_BITS+1){1'b0}}};
    num_calc  = $signed(
                  {{(wtcw_pkg::NUM_W-wtcw_pkg::ROW_W-1){in_top[wtcw_pkg::ROW_W-1]}}, in_top, 1'b0}
                - {{(wtcw_pkg::NUM_W-wtcw_pkg::OFFS_W){1'b0}}, half_offs}
                + {{(wtcw_pkg::NUM_W-wtcw_pkg::ROW_W){in_wall[wtcw_pkg::ROW_W-1]}}, in_wall});
  end

  // Divider operands and quotient saturation
  always_comb begin
    num_pos       = ~num[wtcw_pkg::NUM_W-1] && (num != '0);
    row_dividend  = wtcw_pkg::DIV_W'(num[wtcw_pkg::NUM_W-2:0] * texture_height);
    row_divisor   = {in_wall[wtcw_pkg::ROW_W-2:0], 1'b0};
    step_dividend = {texture_height, {(wtcw_pkg::ACC_FRAC_BITS+wtcw_pkg::ROW_FRAC_BITS){1'b0}}};
    row_acc_q     = (div_quotient[wtcw_pkg::DIV_W-1:wtcw_pkg::ACC_INT_W] != '0)
                    ? wtcw_pkg::ACC_MAX
                    : {div_quotient[wtcw_pkg::ACC_INT_W-1:0], {wtcw_pkg::ACC_FRAC_BITS{1'b0}}};
    step_q        = (div_quotient[wtcw_pkg::DIV_W-1:wtcw_pkg::ACC_W] != '0)
                    ? wtcw_pkg::ACC_MAX : div_quotient[wtcw_pkg::ACC_W-1:0];

    div_start    = 1'b0;
    div_dividend = step_dividend;
    div_divisor  = in_wall;
    if (state == ST_MUL) begin
      div_start = 1'b1;
      if (num_pos) begin
        div_dividend = row_dividend;
        div_divisor  = row_divisor;
      end
    end else if (state == ST_DIV_ROW && div_done) begin
      div_start = 1'b1;
    end
  end

  // Step item: address, overflow, row and accumulator advance
  always_comb begin
    at_end    = current_row >= end_row;
    trow      = texel_row_acc[wtcw_pkg::ACC_W-1:wtcw_pkg::ACC_FRAC_BITS];
    addr_full = wtcw_pkg::ADDR_FULL_W'(trow * texture_width)
              + wtcw_pkg::ADDR_FULL_W'(held_texel_column);
    addr_ovf  = (texel_row_acc == wtcw_pkg::ACC_MAX)
              || ({1'b0, trow} >= texture_height)
              || (addr_full[wtcw_pkg::ADDR_FULL_W-1:wtcw_pkg::ADDR_W] != '0);
    row_inc   = $signed({current_row[wtcw_pkg::ROW_W-1], current_row})
              + $signed((wtcw_pkg::ROW_W+1)'(1 << wtcw_pkg::ROW_FRAC_BITS));
    row_next  = (row_inc > $signed({end_row[wtcw_pkg::ROW_W-1], end_row}))
              ? end_row : row_inc[wtcw_pkg::ROW_W-1:0];
    acc_sum   = {1'b0, texel_row_acc} + {1'b0, texel_row_step};
    acc_next  = acc_sum[wtcw_pkg::ACC_W] ? wtcw_pkg::ACC_MAX : acc_sum[wtcw_pkg::ACC_W-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height  <= wtcw_pkg::SCREEN_HEIGHT_RST;
      texture_width  <= wtcw_pkg::TEXTURE_WIDTH_RST;
      texture_height <= wtcw_pkg::TEXTURE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtcw_pkg::CFG_SCREEN_HEIGHT:  screen_height  <= cfg_data;
        wtcw_pkg::CFG_TEXTURE_WIDTH:  texture_width  <= cfg_data[wtcw_pkg::TW_W-1:0];
        wtcw_pkg::CFG_TEXTURE_HEIGHT: texture_height <= cfg_data[wtcw_pkg::TW_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_side  <= s_tdata[wtcw_pkg::IN_SIDE_LSB];
      in_angle <= s_tdata[wtcw_pkg::IN_ANGLE_LSB +: wtcw_pkg::ANGLE_BITS];
      in_door  <= s_tdata[wtcw_pkg::IN_DOOR_LSB];
      in_open  <= s_tdata[wtcw_pkg::IN_OPEN_LSB];
      in_tcol  <= s_tdata[wtcw_pkg::IN_TCOL_LSB +: wtcw_pkg::COL_W];
      in_top   <= s_tdata[wtcw_pkg::IN_TOP_LSB +: wtcw_pkg::ROW_W];
      in_bot   <= s_tdata[wtcw_pkg::IN_BOT_LSB +: wtcw_pkg::ROW_W];
      in_wall  <= s_tdata[wtcw_pkg::IN_WALL_LSB +: wtcw_pkg::ROW_W];
      in_scol  <= s_tdata[wtcw_pkg::IN_SCOL_LSB +: wtcw_pkg::SCOL_W];
    end
  end

  // Sequencer, column state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      column_active  <= 1'b0;
      current_row    <= '0;
      end_row        <= '0;
      texel_row_acc  <= '0;
      texel_row_step <= '0;
      held_texel_column <= '0;
      held_texture   <= '0;
      held_column    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (in_func == wtcw_pkg::FUNC_BEGIN) begin
            if (reject) begin
              if (out_free) begin
                column_active <= 1'b0;
                m_tvalid <= 1'b1;
                m_tuser  <= wtcw_pkg::STATUS_REJECT;
                out_tex  <= tex_pick;
                out_addr <= '0;
                out_col  <= in_scol;
                out_row  <= '0;
                state    <= ST_IDLE;
              end
            end else begin
              column_active     <= 1'b0;
              num               <= num_calc;
              current_row       <= in_top;
              end_row           <= in_bot;
              held_texel_column <= in_tcol[wtcw_pkg::ACC_INT_W-1:0];
              held_texture      <= tex_pick;
              held_column       <= in_scol;
              state             <= ST_MUL;
            end
          end else if (!column_active) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            out_tex  <= held_texture;
            out_col  <= held_column;
            out_row  <= current_row[wtcw_pkg::ROW_W-1:wtcw_pkg::ROW_FRAC_BITS];
            state    <= ST_IDLE;
            if (at_end) begin
              column_active <= 1'b0;
              m_tuser  <= wtcw_pkg::STATUS_DONE;
              out_addr <= '0;
            end else if (addr_ovf) begin
              column_active <= 1'b0;
              m_tuser  <= wtcw_pkg::STATUS_STOP;
              out_addr <= '0;
            end else begin
              m_tuser       <= wtcw_pkg::STATUS_PIXEL;
              out_addr      <= addr_full[wtcw_pkg::ADDR_W-1:0];
              current_row   <= row_next;
              texel_row_acc <= acc_next;
            end
          end
        end
        ST_MUL: begin
          if (num_pos) begin
            state <= ST_DIV_ROW;
          end else begin
            texel_row_acc <= '0;
            state         <= ST_DIV_STEP;
          end
        end
        ST_DIV_ROW: begin
          if (div_done) begin
            texel_row_acc <= row_acc_q;
            state         <= ST_DIV_STEP;
          end
        end
        ST_DIV_STEP: begin
          if (div_done) begin
            texel_row_step <= step_q;
            column_active  <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(wtcw_pkg::OUT_TDATA_W-wtcw_pkg::OUT_USED_W){1'b0}},
                    out_row, out_col, out_addr, out_tex};

  wtcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

FILE: sv/wtcw_div.sv
// Restoring divider, one quotient bit per cycle
module wtcw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wtcw_pkg::DIV_W-1:0]  dividend,
  input  logic [wtcw_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [wtcw_pkg::DIV_W-1:0]  quotient
);

  logic                        busy;
  logic [wtcw_pkg::CNT_W-1:0]  count;
  logic [wtcw_pkg::DVS_W-1:0]  rem;
  logic [wtcw_pkg::DVS_W-1:0]  dvs;
  logic [wtcw_pkg::DIV_W-1:0]  quo;
  logic [wtcw_pkg::DVS_W:0]    shifted;
  logic [wtcw_pkg::DVS_W+1:0]  diff;
  logic                        fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, quo[wtcw_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = ~diff[wtcw_pkg::DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= wtcw_pkg::CNT_W'(wtcw_pkg::DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == wtcw_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[wtcw_pkg::DVS_W-1:0] : shifted[wtcw_pkg::DVS_W-1:0];
      quo <= {quo[wtcw_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: sv/wtcw_checker.sv
// Port-level checks for the column walker
module wtcw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [wtcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [wtcw_pkg::CFG_W-1:0]       cfg_data,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [wtcw_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [wtcw_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [wtcw_pkg::STATUS_W-1:0]    m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken back to back");

  // only pixel results carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != wtcw_pkg::STATUS_PIXEL
      |-> m_tdata[wtcw_pkg::OUT_ADDR_LSB +: wtcw_pkg::ADDR_W] == '0)
    else $error("non-pixel result with nonzero address");

  // texture code stays within the six textures
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[wtcw_pkg::OUT_TEX_LSB +: wtcw_pkg::TEX_W] <= wtcw_pkg::TEX_DOOR_CLOSED)
    else $error("texture code out of range");

endmodule

bind wall_texture_column_walker_core wtcw_checker u_wtcw_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wtcw_pkg::*;

  // One input item, field by field
  typedef struct packed {
    logic                     func;
    logic                     side;
    logic [ANGLE_BITS-1:0]    angle;
    logic                     door;
    logic                     open;
    logic signed [COL_W-1:0]  tcol;
    logic signed [ROW_W-1:0]  top;
    logic signed [ROW_W-1:0]  bot;
    logic signed [ROW_W-1:0]  wall;
    logic [SCOL_W-1:0]        scol;
  } walk_item_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TEX_W-1:0]    tex;
    logic [ADDR_W-1:0]   addr;
    logic [SCOL_W-1:0]   col;
    logic [OROW_W-1:0]   row;
  } texel_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;

  wall_texture_column_walker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Walker copy: registers and column state
  logic [SH_W-1:0]         cfg_sh;
  logic [TW_W-1:0]         cfg_tw;
  logic [TW_W-1:0]         cfg_th;
  logic                    active;
  logic signed [ROW_W-1:0] cur_row;
  logic signed [ROW_W-1:0] end_row_q;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        step_q;
  logic [7:0]              hcol;
  logic [TEX_W-1:0]        htex;
  logic [SCOL_W-1:0]       hscol;

  texel_result_t column_results[$];
  texel_result_t oldest;

  logic steady;
  logic hold_req;
  int   hold_cnt;
  int   fail_count;
  int   items_sent;
  int   begins_sent;
  int   results_seen;
  int   settings_used;

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [TEX_W-1:0] choose_texture(input logic side,
                                                      input logic [ANGLE_BITS-1:0] angle,
                                                      input logic door, input logic open);
    if (door) return open ? TEX_DOOR_OPEN : TEX_DOOR_CLOSED;
    if (side) return (angle > 0 && angle < ANG_PI) ? TEX_NORTH : TEX_SOUTH;
    return (angle > ANG_HALF_PI && angle < ANG_3HALF_PI) ? TEX_WEST : TEX_EAST;
  endfunction

  // Expected results of one accepted item; updates the walker copy
  task automatic walk_item(input walk_item_t it);
    texel_result_t           r;
    logic                    emit;
    longint                  wall_l, top_l, col_l, num_l, row_l, step_l, half_l;
    longint                  tw_l, th_l, tr_l, addr_l, cur_l, end_l, sum_l;
    logic signed [ROW_W-1:0] row_q;
    emit = 1'b0;
    r = '0;
    tw_l = cfg_tw;
    th_l = cfg_th;
    if (it.func == FUNC_BEGIN) begin
      r.tex = choose_texture(it.side, it.angle, it.door, it.open);
      wall_l = it.wall;
      top_l = it.top;
      col_l = it.tcol;
      active = 1'b0;
      if (wall_l <= 0 || col_l < 0 || col_l >= tw_l || col_l > 255) begin
        r.status = STATUS_REJECT;
        r.col = it.scol;
        emit = 1'b1;
      end else begin
        // start texel row, clamped at zero, saturating in Q8.16
        half_l = cfg_sh >> 1;
        num_l = 2 * top_l - (half_l << (ROW_FRAC_BITS + 1)) + wall_l;
        if (num_l <= 0) begin
          acc = '0;
        end else begin
          row_l = num_l * th_l / (2 * wall_l);
          acc = (row_l > 255) ? ACC_MAX : ACC_W'(row_l << ACC_FRAC_BITS);
        end
        step_l = (th_l << (ACC_FRAC_BITS + ROW_FRAC_BITS)) / wall_l;
        step_q = (step_l > longint'(ACC_MAX)) ? ACC_MAX : ACC_W'(step_l);
        cur_row = it.top;
        end_row_q = it.bot;
        hcol = col_l[7:0];
        htex = r.tex;
        hscol = it.scol;
        active = 1'b1;
      end
    end else if (active) begin
      r.tex = htex;
      r.col = hscol;
      row_q = cur_row >>> ROW_FRAC_BITS;
      r.row = row_q[OROW_W-1:0];
      emit = 1'b1;
      if (cur_row >= end_row_q) begin
        r.status = STATUS_DONE;
        active = 1'b0;
      end else begin
        tr_l = acc[ACC_W-1:ACC_FRAC_BITS];
        addr_l = tr_l * tw_l + longint'(hcol);
        if (acc == ACC_MAX || tr_l >= th_l || addr_l > 65535) begin
          r.status = STATUS_STOP;
          active = 1'b0;
        end else begin
          r.status = STATUS_PIXEL;
          r.addr = addr_l[ADDR_W-1:0];
          // row advance saturates at the bottom
          cur_l = cur_row;
          end_l = end_row_q;
          cur_row = (cur_l + 16 > end_l) ? end_row_q : ROW_W'(cur_l + 16);
          sum_l = longint'(acc) + longint'(step_q);
          acc = (sum_l > longint'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum_l);
        end
      end
    end
    if (emit) column_results.push_back(r);
  endtask

  // Offer one item, wait for acceptance, then predict
  task automatic send_item(input walk_item_t it);
    logic [IN_TDATA_W-1:0] data;
    if (!steady && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    data = '0;
    data[IN_SIDE_LSB]                = it.side;
    data[IN_ANGLE_LSB +: ANGLE_BITS] = it.angle;
    data[IN_DOOR_LSB]                = it.door;
    data[IN_OPEN_LSB]                = it.open;
    data[IN_TCOL_LSB +: COL_W]       = it.tcol;
    data[IN_TOP_LSB +: ROW_W]        = it.top;
    data[IN_BOT_LSB +: ROW_W]        = it.bot;
    data[IN_WALL_LSB +: ROW_W]       = it.wall;
    data[IN_SCOL_LSB +: SCOL_W]      = it.scol;
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    walk_item(it);
    items_sent++;
    if (it.func == FUNC_BEGIN) begins_sent++;
  endtask

  function automatic walk_item_t begin_item(input logic side, input logic [ANGLE_BITS-1:0] angle,
                                            input logic door, input logic open, input int tcol,
                                            input int top, input int bot, input int wall);
    walk_item_t it;
    it.func  = FUNC_BEGIN;
    it.side  = side;
    it.angle = angle;
    it.door  = door;
    it.open  = open;
    it.tcol  = COL_W'(tcol);
    it.top   = ROW_W'(top);
    it.bot   = ROW_W'(bot);
    it.wall  = ROW_W'(wall);
    it.scol  = SCOL_W'($urandom);
    return it;
  endfunction

  // Fully random item; a step ignores its payload
  function automatic walk_item_t noise_item(input logic func);
    walk_item_t it;
    it = begin_item($urandom_range(0, 1), $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom, $urandom, $urandom, $urandom);
    it.func = func;
    return it;
  endfunction

  function automatic int clamp_row(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Begin item followed by about as many steps as the slice needs
  task automatic send_random_column();
    walk_item_t it;
    int         wall, top, bot, half, span, need, n_steps, tcol, pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) wall = $urandom_range(1, 15);
    else if (pick < 4) wall = $urandom_range(16384, 32767);
    else wall = $urandom_range(16, 2048);
    if (cfg_tw == 0 || $urandom_range(0, 19) == 0) tcol = int'($urandom_range(0, 2047)) - 1024;
    else tcol = $urandom_range(0, (cfg_tw > 256 ? 256 : int'(cfg_tw)) - 1);
    // centre the slice, then shift it so the start row ranges from clamped to past the end
    half = cfg_sh >> 1;
    top = half * 16 - wall / 2 + int'($urandom_range(0, wall + wall / 4)) - wall / 4;
    if ($urandom_range(0, 9) == 0) top = int'($urandom_range(0, 65535)) - 32768;
    pick = $urandom_range(0, 19);
    if (pick == 0) span = -int'($urandom_range(0, 300));
    else if (pick == 1) span = int'($urandom_range(21, 200)) * 16;
    else span = int'($urandom_range(0, 20)) * 16 + int'($urandom_range(0, 15));
    bot = clamp_row(top + span);
    top = clamp_row(top);
    need = (bot > top) ? (bot - top + 15) / 16 + 1 : 1;
    n_steps = need + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) n_steps = $urandom_range(0, need);
    it = begin_item($urandom_range(0, 1), $urandom, $urandom_range(0, 7) == 0,
                    $urandom_range(0, 1), tcol, top, bot, wall);
    send_item(it);
    repeat (n_steps) send_item(noise_item(FUNC_STEP));
  endtask

  // Let every expected result arrive, then give a pending begin time to finish
  task automatic drain_results();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (column_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (column_results.size() != 0) begin
      $error("%0d expected results never arrived", column_results.size());
      fail_count++;
      column_results.delete();
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_SCREEN_HEIGHT:  cfg_sh = SH_W'(value);
      CFG_TEXTURE_WIDTH:  cfg_tw = TW_W'(value);
      CFG_TEXTURE_HEIGHT: cfg_th = TW_W'(value);
      default: ;
    endcase
  endtask

  // New register setting, then random columns mixed with noise
  task automatic run_setting(input int unsigned sh, input int unsigned tw, input int unsigned th,
                             input int n_items);
    int start;
    drain_results();
    write_reg(CFG_SCREEN_HEIGHT, sh);
    write_reg(CFG_TEXTURE_WIDTH, tw);
    write_reg(CFG_TEXTURE_HEIGHT, th);
    cfg_we <= 1'b0;
    settings_used++;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 99) < 15) send_item(noise_item($urandom_range(0, 1)));
      else send_random_column();
    end
  endtask

  // Steps before any begin are dropped
  task automatic test_idle_steps();
    send_item(noise_item(FUNC_STEP));
    send_item(noise_item(FUNC_STEP));
  endtask

  // Rejected begins expose the chosen texture directly
  task automatic test_texture_choice();
    send_item(begin_item(1, '0, 0, 0, 5, 100, 200, 0));
    send_item(begin_item(1, 16'd1, 0, 0, 5, 100, 200, -1));
    send_item(begin_item(1, ANG_PI - 1, 0, 0, 5, 100, 200, -32768));
    send_item(begin_item(1, ANG_PI, 0, 0, -1024, 100, 200, 100));
    send_item(begin_item(1, 16'hFFFF, 0, 0, 1023, 100, 200, 100));
    send_item(begin_item(0, ANG_HALF_PI, 0, 0, 64, 100, 200, 256));
    send_item(begin_item(0, ANG_HALF_PI + 1, 0, 0, -1, 100, 200, 256));
    send_item(begin_item(0, ANG_3HALF_PI - 1, 0, 0, 5, 100, 200, 0));
    send_item(begin_item(0, ANG_3HALF_PI, 0, 0, 5, 100, 200, 0));
    send_item(begin_item(0, $urandom, 1, 1, 5, 100, 200, 0));
    send_item(begin_item(1, $urandom, 1, 0, 5, 100, 200, 0));
  endtask

  // Four pixels, a partial last row, done, one ignored step
  task automatic test_column_walk();
    send_item(begin_item(1, 16'h2000, 0, 0, 63, 3712, 3765, 256));
    repeat (6) send_item(noise_item(FUNC_STEP));
  endtask

  // Row at the top of the range, saturated step, start row past the texture
  task automatic test_row_edges();
    send_item(begin_item(0, $urandom, 0, 0, 0, 32760, 32767, 32767));
    repeat (2) send_item(noise_item(FUNC_STEP));
    send_item(begin_item(1, ANG_HALF_PI, 0, 0, 10, 3840, 3904, 1));
    repeat (3) send_item(noise_item(FUNC_STEP));
    send_item(begin_item(0, ANG_PI, 0, 1, 20, 4096, 4400, 256));
    send_item(noise_item(FUNC_STEP));
  endtask

  task automatic test_random_settings();
    run_setting(480, 64, 64, 300);
    run_setting(1, 1, 1, 120);
    run_setting(2047, 256, 256, 200);
    run_setting(240, 32, 128, 200);
    run_setting($urandom_range(1, 2047), $urandom_range(1, 256), $urandom_range(1, 256), 300);
    run_setting(1023, 511, 511, 100);
    run_setting(480, 0, 64, 60);
    run_setting(480, 64, 0, 60);
  endtask

  // No idling on either side for a whole setting
  task automatic test_steady_stream();
    steady = 1'b1;
    run_setting(640, 128, 96, 200);
    steady = 1'b0;
  endtask

  // Receiver holds off while a tall column keeps coming
  task automatic test_backpressure();
    drain_results();
    steady = 1'b1;
    hold_req = 1'b1;
    send_item(begin_item(0, $urandom, 0, 0, 5, 3000, 3640, 1024));
    repeat (42) send_item(noise_item(FUNC_STEP));
    steady = 1'b0;
  endtask

  // Receiver: random idling, or one long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (column_results.size() == 0) begin
        $error("unexpected result, status %0d", m_tuser);
        fail_count++;
      end else begin
        oldest = column_results.pop_front();
        if (m_tuser !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[OUT_TEX_LSB +: TEX_W] !== oldest.tex) begin
          $error("texture_id: expected %0d, got %0d", oldest.tex, m_tdata[OUT_TEX_LSB +: TEX_W]);
          fail_count++;
        end
        if (m_tdata[OUT_ADDR_LSB +: ADDR_W] !== oldest.addr) begin
          $error("texel_address: expected %0d, got %0d", oldest.addr,
                 m_tdata[OUT_ADDR_LSB +: ADDR_W]);
          fail_count++;
        end
        if (m_tdata[OUT_COL_LSB +: SCOL_W] !== oldest.col) begin
          $error("out_column: expected %0d, got %0d", oldest.col, m_tdata[OUT_COL_LSB +: SCOL_W]);
          fail_count++;
        end
        if (m_tdata[OUT_ROW_LSB +: OROW_W] !== oldest.row) begin
          $error("out_row: expected %0d, got %0d", $signed(oldest.row),
                 $signed(m_tdata[OUT_ROW_LSB +: OROW_W]));
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_BEGIN;
    steady = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    items_sent = 0;
    begins_sent = 0;
    results_seen = 0;
    settings_used = 1;
    cfg_sh = SCREEN_HEIGHT_RST;
    cfg_tw = TEXTURE_WIDTH_RST;
    cfg_th = TEXTURE_HEIGHT_RST;
    active = 1'b0;
    cur_row = '0;
    end_row_q = '0;
    acc = '0;
    step_q = '0;
    hcol = '0;
    htex = '0;
    hscol = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_steps();
    test_texture_choice();
    test_column_walk();
    test_row_edges();
    test_random_settings();
    test_steady_stream();
    test_backpressure();
    drain_results();

    $display("Sent %0d items (%0d column begins) under %0d register settings; %0d results checked.",
             items_sent, begins_sent, settings_used, results_seen);
    $display("Covered texture choice, rejects, clamped and saturated rows, stops and a long stall.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
